// ===== src/i2cerm_pkg.sv =====
package i2cerm_pkg;

  localparam int unsigned LastStep = 145;
  localparam logic [6:0] DevSelReset = 7'd80;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_SCL_HI,
    ACT_SCL_LO,
    ACT_SDA_HI,
    ACT_SDA_LO,
    ACT_SDA_BIT,
    ACT_SAMPLE
  } act_t;

  typedef enum logic [1:0] {
    BYTE_SEL_W,
    BYTE_ADDR_HI,
    BYTE_ADDR_LO,
    BYTE_SEL_R
  } byte_src_t;

  typedef struct packed {
    act_t      act;
    byte_src_t byte_src;
    logic [2:0] bit_idx;
  } step_dec_t;

  typedef struct packed {
    logic       scl_released;
    logic       sda_released;
    logic       busy_res;
    logic       refused;
    logic       done_res;
    logic [7:0] read_data;
  } res_t;

  function automatic act_t start_act(input logic [1:0] k);
    act_t a;
    case (k)
      2'd0:    a = ACT_SDA_HI;
      2'd1:    a = ACT_SCL_HI;
      2'd2:    a = ACT_SDA_LO;
      default: a = ACT_SCL_LO;
    endcase
    return a;
  endfunction

  // One byte slot: eight bits of three steps each, then a released ack clock.
  function automatic step_dec_t send_dec(input logic [4:0] r, input byte_src_t src);
    step_dec_t d;
    logic [2:0] b;
    logic [4:0] sub;
    b = 3'd0;
    for (int k = 1; k < 8; k++) begin
      if (r >= 5'(3 * k)) begin
        b = 3'(k);
      end
    end
    sub = r - 5'(3 * b);
    d.byte_src = src;
    d.bit_idx = b;
    if (r < 5'd24) begin
      if (sub == 5'd0) begin
        d.act = ACT_SDA_BIT;
      end else if (sub == 5'd1) begin
        d.act = ACT_SCL_HI;
      end else begin
        d.act = ACT_SCL_LO;
      end
    end else if (r == 5'd24 || r == 5'd25) begin
      d.act = ACT_SDA_HI;
    end else if (r == 5'd26) begin
      d.act = ACT_SCL_HI;
    end else begin
      d.act = ACT_SCL_LO;
    end
    return d;
  endfunction

  function automatic step_dec_t step_decode(input logic [7:0] s);
    step_dec_t d;
    logic [7:0] j;
    d.act = ACT_NONE;
    d.byte_src = BYTE_SEL_W;
    d.bit_idx = 3'd0;
    if (s == 8'd0) begin
      d.act = ACT_NONE;
    end else if (s <= 8'd4) begin
      d.act = start_act(2'(s - 8'd1));
    end else if (s <= 8'd88) begin
      j = s - 8'd5;
      if (j >= 8'd56) begin
        d = send_dec(5'(j - 8'd56), BYTE_ADDR_LO);
      end else if (j >= 8'd28) begin
        d = send_dec(5'(j - 8'd28), BYTE_ADDR_HI);
      end else begin
        d = send_dec(5'(j), BYTE_SEL_W);
      end
    end else if (s <= 8'd92) begin
      d.act = start_act(2'(s - 8'd89));
    end else if (s <= 8'd120) begin
      d = send_dec(5'(s - 8'd93), BYTE_SEL_R);
    end else if (s == 8'd121) begin
      d.act = ACT_SDA_HI;
    end else if (s <= 8'd137) begin
      d.act = (s[0] == 1'b0) ? ACT_SCL_HI : ACT_SAMPLE;
    end else begin
      case (s)
        8'd138:  d.act = ACT_SDA_HI;
        8'd139:  d.act = ACT_SCL_HI;
        8'd140:  d.act = ACT_SCL_LO;
        8'd141:  d.act = ACT_SDA_HI;
        8'd142:  d.act = ACT_SCL_LO;
        8'd143:  d.act = ACT_SDA_LO;
        8'd144:  d.act = ACT_SCL_HI;
        default: d.act = ACT_SDA_HI;
      endcase
    end
    return d;
  endfunction

endpackage

// ===== src/i2cerm_core.sv =====
module i2cerm_core
  import i2cerm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        kind,
  input  logic [15:0] mem_address,
  input  logic        sda_level,
  input  logic        cfg_write,
  input  logic [6:0]  cfg_data,
  output res_t        res
);

  logic [7:0]  step_count, step_count_next;
  logic [15:0] address_hold, address_hold_next;
  logic [7:0]  receive_shift, receive_shift_next;
  logic        scl_pin, scl_pin_next;
  logic        sda_pin, sda_pin_next;
  logic [6:0]  device_select;

  step_dec_t  dec;
  logic [7:0] tx_byte;
  logic       refused_c;
  logic       done_c;

  always_comb begin
    dec = step_decode(step_count);
    case (dec.byte_src)
      BYTE_SEL_W:   tx_byte = {device_select, 1'b0};
      BYTE_ADDR_HI: tx_byte = address_hold[15:8];
      BYTE_ADDR_LO: tx_byte = address_hold[7:0];
      default:      tx_byte = {device_select, 1'b1};
    endcase
  end

  always_comb begin
    step_count_next = step_count;
    address_hold_next = address_hold;
    receive_shift_next = receive_shift;
    scl_pin_next = scl_pin;
    sda_pin_next = sda_pin;
    refused_c = 1'b0;
    done_c = 1'b0;
    if (kind == 1'b0) begin
      if (step_count != 8'd0) begin
        refused_c = 1'b1;
      end else begin
        address_hold_next = mem_address;
        receive_shift_next = 8'd0;
        step_count_next = 8'd1;
      end
    end else if (step_count != 8'd0) begin
      unique case (dec.act)
        ACT_SCL_HI:  scl_pin_next = 1'b1;
        ACT_SCL_LO:  scl_pin_next = 1'b0;
        ACT_SDA_HI:  sda_pin_next = 1'b1;
        ACT_SDA_LO:  sda_pin_next = 1'b0;
        ACT_SDA_BIT: sda_pin_next = tx_byte[3'd7 - dec.bit_idx];
        ACT_SAMPLE: begin
          receive_shift_next = {receive_shift[6:0], sda_level};
          scl_pin_next = 1'b0;
        end
        default: ;
      endcase
      if (step_count == 8'(LastStep)) begin
        step_count_next = 8'd0;
        done_c = 1'b1;
      end else begin
        step_count_next = step_count + 8'd1;
      end
    end
  end

  always_comb begin
    res.scl_released = scl_pin_next;
    res.sda_released = sda_pin_next;
    res.busy_res = (step_count_next != 8'd0);
    res.refused = refused_c;
    res.done_res = done_c;
    res.read_data = receive_shift_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_count <= 8'd0;
      address_hold <= 16'd0;
      receive_shift <= 8'd0;
      scl_pin <= 1'b1;
      sda_pin <= 1'b1;
      device_select <= DevSelReset;
    end else begin
      if (cfg_write) begin
        device_select <= cfg_data;
      end
      if (en) begin
        step_count <= step_count_next;
        address_hold <= address_hold_next;
        receive_shift <= receive_shift_next;
        scl_pin <= scl_pin_next;
        sda_pin <= sda_pin_next;
      end
    end
  end

endmodule

// ===== src/i2c_eeprom_random_read_master_unit.sv =====
// I2C master for a one-byte EEPROM random read. A request transfer (kind 0) latches
// the 16-bit memory address when idle; each tick transfer (kind 1) then advances the bus by one
// pin step, and a full read takes 145 ticks ending in a NACK and a STOP. Every input
// transfer yields exactly one result transfer carrying the pin levels, busy, refused,
// done and the receive byte. One input transfer is taken per clock cycle while in_stall is
// low, and its result is registered. The step decode and state update sit between the
// sequencer state and a two-entry output register, so the input side keeps accepting while
// a single result waits and stalls only when both entries are full.
module i2c_eeprom_random_read_master_unit
  import i2cerm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        kind,
  input  logic [15:0] mem_address,
  input  logic        sda_level,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        scl_released,
  output logic        sda_released,
  output logic        busy_res,
  output logic        refused,
  output logic        done_res,
  output logic [7:0]  read_data,
  input  logic        cfg_write,
  input  logic [6:0]  cfg_data
);

  res_t res_c;
  res_t out_res;
  res_t skid_res;
  logic skid_valid;
  logic accept;
  logic take;

  assign in_stall = skid_valid;
  assign accept = in_valid && !skid_valid;
  assign take = out_valid && !out_stall;

  i2cerm_core u_core (
    .clk         (clk),
    .rst         (rst),
    .en          (accept),
    .kind        (kind),
    .mem_address (mem_address),
    .sda_level   (sda_level),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data),
    .res         (res_c)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (take) begin
      if (skid_valid) begin
        out_res <= skid_res;
        skid_valid <= 1'b0;
      end else if (accept) begin
        out_res <= res_c;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (accept) begin
      if (!out_valid) begin
        out_res <= res_c;
        out_valid <= 1'b1;
      end else begin
        skid_res <= res_c;
        skid_valid <= 1'b1;
      end
    end
  end

  assign scl_released = out_res.scl_released;
  assign sda_released = out_res.sda_released;
  assign busy_res = out_res.busy_res;
  assign refused = out_res.refused;
  assign done_res = out_res.done_res;
  assign read_data = out_res.read_data;

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("Skid entry holds a result while the output entry is empty.");

  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && out_stall))
    else $error("Skid entry filled without a stalled output.");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && done_res) |-> (!busy_res && !refused))
    else $error("Done result reports busy or refused.");

  a_refused_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && refused) |-> busy_res)
    else $error("Refused result reports idle.");
`endif

endmodule

// ===== tb/tb.sv =====
module tb;
  import i2cerm_pkg::*;

  localparam logic KindRequest = 1'b0;
  localparam logic KindTick = 1'b1;
  localparam int WatchdogLimit = 2000;
  localparam int ReportLimit = 10;
  localparam int DirRows = 14;
  localparam int ReadsPerSetting = 2;
  localparam int Settings = 5;

  localparam res_t IdleRes = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00};
  localparam res_t BusyRes = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00};
  localparam res_t RefusedRes = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 8'h00};

  typedef struct packed {
    logic       chk;
    logic       kind;
    logic [15:0] addr;
    logic       sda;
    res_t       want;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic        kind;
  logic [15:0] mem_address;
  logic        sda_level;
  logic        out_valid;
  logic        out_stall;
  logic        scl_released;
  logic        sda_released;
  logic        busy_res;
  logic        refused;
  logic        done_res;
  logic [7:0]  read_data;
  logic        cfg_write;
  logic [6:0]  cfg_data;

  // Predicted bus state, kept in step with every accepted input transfer.
  logic [6:0]  dev_sel;
  logic [7:0]  step_cnt;
  logic [15:0] addr_hold;
  logic [7:0]  rx_shift;
  logic        scl_st;
  logic        sda_st;

  res_t        bus_result_q[$];
  res_t        seen;
  res_t        want_r;
  dir_row_t    dir_tab [DirRows];
  int          err_count = 0;
  int          idle_cycles = 0;
  int          stall_left = 0;
  int unsigned cyc_cnt = 0;
  bit          calm = 1'b0;

  i2c_eeprom_random_read_master_unit dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .kind         (kind),
    .mem_address  (mem_address),
    .sda_level    (sda_level),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .scl_released (scl_released),
    .sda_released (sda_released),
    .busy_res     (busy_res),
    .refused      (refused),
    .done_res     (done_res),
    .read_data    (read_data),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int gap_len();
    if ($urandom_range(0, 99) < 85) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  function automatic void start_cond(input int k);
    case (k)
      0:       sda_st = 1'b1;
      1:       scl_st = 1'b1;
      2:       sda_st = 1'b0;
      default: scl_st = 1'b0;
    endcase
  endfunction

  // Eight bits of three pin steps each, then a released acknowledge clock.
  function automatic void send_slot(input logic [7:0] b, input int r);
    if (r < 24) begin
      case (r % 3)
        0:       sda_st = b[7 - r / 3];
        1:       scl_st = 1'b1;
        default: scl_st = 1'b0;
      endcase
    end else if (r == 24 || r == 25) begin
      sda_st = 1'b1;
    end else if (r == 26) begin
      scl_st = 1'b1;
    end else begin
      scl_st = 1'b0;
    end
  endfunction

  function automatic void bus_step(input logic [7:0] s, input logic s_in);
    logic [7:0] sel_byte;
    int j;
    sel_byte = {dev_sel, 1'b0};
    if (s <= 4) begin
      start_cond(s - 1);
    end else if (s <= 88) begin
      j = s - 5;
      case (j / 28)
        0:       send_slot(sel_byte, j % 28);
        1:       send_slot(addr_hold[15:8], j % 28);
        default: send_slot(addr_hold[7:0], j % 28);
      endcase
    end else if (s <= 92) begin
      start_cond(s - 89);
    end else if (s <= 120) begin
      send_slot(sel_byte | 8'h01, s - 93);
    end else if (s == 121) begin
      sda_st = 1'b1;
    end else if (s <= 137) begin
      // The tick that pulls SCL low shifts in the level seen while SCL was high.
      if (s[0] == 1'b0) begin
        scl_st = 1'b1;
      end else begin
        rx_shift = {rx_shift[6:0], s_in};
        scl_st = 1'b0;
      end
    end else begin
      case (s)
        8'd138:  sda_st = 1'b1;
        8'd139:  scl_st = 1'b1;
        8'd140:  scl_st = 1'b0;
        8'd141:  sda_st = 1'b1;
        8'd142:  scl_st = 1'b0;
        8'd143:  sda_st = 1'b0;
        8'd144:  scl_st = 1'b1;
        default: sda_st = 1'b1;
      endcase
    end
  endfunction

  function automatic res_t predict_bus_result(input logic k, input logic [15:0] a,
                                              input logic s_in);
    res_t r;
    logic refuse;
    logic fin;
    refuse = 1'b0;
    fin = 1'b0;
    if (step_cnt > LastStep) begin
      step_cnt = 8'd0;
    end
    if (k == KindRequest) begin
      if (step_cnt != 8'd0) begin
        refuse = 1'b1;
      end else begin
        addr_hold = a;
        rx_shift = 8'h00;
        step_cnt = 8'd1;
      end
    end else if (step_cnt != 8'd0) begin
      bus_step(step_cnt, s_in);
      if (step_cnt == LastStep) begin
        step_cnt = 8'd0;
        fin = 1'b1;
      end else begin
        step_cnt = step_cnt + 8'd1;
      end
    end
    r.scl_released = scl_st;
    r.sda_released = sda_st;
    r.busy_res = (step_cnt != 8'd0);
    r.refused = refuse;
    r.done_res = fin;
    r.read_data = rx_shift;
    return r;
  endfunction

  task automatic push_item(input logic k, input logic [15:0] a, input logic s_in,
                           input logic typed, input res_t want);
    int gap;
    res_t pred;
    gap = (!calm && $urandom_range(0, 99) < 40) ? gap_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    mem_address <= a;
    sda_level <= s_in;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = predict_bus_result(k, a, s_in);
    bus_result_q.push_back(typed ? want : pred);
  endtask

  function automatic logic [15:0] pick_address();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // One well-formed random read, with refused requests mixed into the ticks.
  task automatic run_read();
    push_item(KindRequest, pick_address(), 1'($urandom), 1'b0, '0);
    while (step_cnt != 8'd0) begin
      if ($urandom_range(0, 99) < 3) begin
        push_item(KindRequest, pick_address(), 1'($urandom), 1'b0, '0);
      end
      push_item(KindTick, 16'($urandom), 1'($urandom), 1'b0, '0);
    end
  endtask

  task automatic set_device(input logic [6:0] v);
    in_valid <= 1'b0;
    while (bus_result_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    dev_sel = v;
  endtask

  always @(posedge clk) begin
    cyc_cnt <= cyc_cnt + 1;
    if (cyc_cnt[7:0] == 8'd0) begin
      calm <= ($urandom_range(0, 3) == 0);
    end
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      seen = '{scl_released, sda_released, busy_res, refused, done_res, read_data};
      if (bus_result_q.size() == 0) begin
        if (err_count < ReportLimit) begin
          $display("unexpected result transfer at %0t: %p", $realtime, seen);
        end
        err_count++;
      end else begin
        want_r = bus_result_q.pop_front();
        if (seen.scl_released !== want_r.scl_released
            || seen.sda_released !== want_r.sda_released
            || seen.busy_res !== want_r.busy_res
            || seen.refused !== want_r.refused
            || seen.done_res !== want_r.done_res
            || seen.read_data !== want_r.read_data) begin
          if (err_count < ReportLimit) begin
            $display("mismatch at %0t: expected scl %b sda %b busy %b refused %b done %b",
                     $realtime, want_r.scl_released, want_r.sda_released, want_r.busy_res,
                     want_r.refused, want_r.done_res);
            $display("  data %h, got scl %b sda %b busy %b refused %b done %b data %h",
                     want_r.read_data, seen.scl_released, seen.sda_released,
                     seen.busy_res, seen.refused, seen.done_res, seen.read_data);
          end
          err_count++;
        end
      end
    end
    if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 99) < 30) begin
      out_stall <= 1'b1;
      stall_left <= gap_len() - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  initial begin
    logic [6:0] setting;
    rst <= 1'b1;
    in_valid <= 1'b0;
    kind <= KindTick;
    mem_address <= 16'h0000;
    sda_level <= 1'b0;
    out_stall <= 1'b0;
    cfg_write <= 1'b0;
    cfg_data <= 7'h00;
    dev_sel = DevSelReset;
    step_cnt = 8'd0;
    addr_hold = 16'h0000;
    rx_shift = 8'h00;
    scl_st = 1'b1;
    sda_st = 1'b1;

    // Idle ticks, a request at the top address, a refused request, the start
    // condition and the first select bits, then another refused request.
    dir_tab = '{
      '{1'b1, KindTick,    16'h0000, 1'b0, IdleRes},
      '{1'b1, KindTick,    16'hFFFF, 1'b1, IdleRes},
      '{1'b1, KindRequest, 16'hFFFF, 1'b0, BusyRes},
      '{1'b1, KindRequest, 16'h0000, 1'b1, RefusedRes},
      '{1'b0, KindTick,    16'h0000, 1'b0, '0},
      '{1'b0, KindTick,    16'h0000, 1'b1, '0},
      '{1'b0, KindTick,    16'h0000, 1'b0, '0},
      '{1'b0, KindTick,    16'h0000, 1'b1, '0},
      '{1'b0, KindRequest, 16'h5555, 1'b0, '0},
      '{1'b0, KindTick,    16'h0000, 1'b1, '0},
      '{1'b0, KindTick,    16'h0000, 1'b0, '0},
      '{1'b0, KindTick,    16'h0000, 1'b1, '0},
      '{1'b0, KindTick,    16'h0000, 1'b1, '0},
      '{1'b0, KindRequest, 16'hAAAA, 1'b0, '0}
    };

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i]) begin
      push_item(dir_tab[i].kind, dir_tab[i].addr, dir_tab[i].sda,
                dir_tab[i].chk, dir_tab[i].want);
    end
    while (step_cnt != 8'd0) begin
      push_item(KindTick, 16'($urandom), 1'($urandom), 1'b0, '0);
    end

    for (int p = 0; p < Settings; p++) begin
      case (p)
        0:       setting = 7'h00;
        1:       setting = 7'h7F;
        2:       setting = 7'h2A;
        default: setting = 7'($urandom_range(0, 127));
      endcase
      set_device(setting);
      for (int n = 0; n < ReadsPerSetting; n++) begin
        repeat ($urandom_range(0, 2)) begin
          push_item(KindTick, 16'($urandom), 1'($urandom), 1'b0, '0);
        end
        run_read();
      end
    end

    in_valid <= 1'b0;
    while (bus_result_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (err_count == 0 && bus_result_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
